FILE: hw/rtl/cdsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditional directive stack package
// Shared constants, codes and types for the conditional directive stack.
// ----------------------------------------------------------------------------
package cdsu_pkg;

  localparam int STACK_DEPTH = 32;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_OUT_W = 6;

  localparam logic [1:0] ACT_PUSH    = 2'd0;
  localparam logic [1:0] ACT_POP     = 2'd1;
  localparam logic [1:0] ACT_INSPECT = 2'd2;

  localparam logic [2:0] DIR_IF     = 3'd0;
  localparam logic [2:0] DIR_IFDEF  = 3'd1;
  localparam logic [2:0] DIR_IFNDEF = 3'd2;
  localparam logic [2:0] DIR_ELIF   = 3'd3;
  localparam logic [2:0] DIR_ELSE   = 3'd4;
  localparam logic [2:0] DIR_ENDIF  = 3'd5;

  localparam logic [1:0] COND_FALSE   = 2'd0;
  localparam logic [1:0] COND_TRUE    = 2'd1;
  localparam logic [1:0] COND_SPECIAL = 2'd2;

  typedef struct packed {
    logic [2:0] dir;
    logic       cond;
    logic       spec;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic pop_step;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic top_open;
  } sts_t;

endpackage

FILE: hw/rtl/cdsu_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditional directive stack controller
// Sequences acceptance, the push, the entry-by-entry pop walk and the result.
// ----------------------------------------------------------------------------
module cdsu_ctrl
  import cdsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  input  logic [1:0] action_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       busy,
  output logic       result_valid_o
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_POP  = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d        = state_q;
    cmd_o          = '0;
    busy           = 1'b1;
    result_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.accept = 1'b1;
          if (action_i == ACT_PUSH) begin
            cmd_o.push = 1'b1;
            state_d    = ST_DONE;
          end else if (action_i == ACT_POP && !sts_i.empty) begin
            state_d = ST_POP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_POP: begin
        cmd_o.pop_step = 1'b1;
        if (sts_i.top_open || sts_i.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        result_valid_o = 1'b1;
        state_d        = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: hw/rtl/cdsu_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditional directive stack datapath
// Holds the entry memory, the fill count, the cached top entry and the flags.
// ----------------------------------------------------------------------------
module cdsu_datapath
  import cdsu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  input  logic [2:0]             dir_type_i,
  input  logic [1:0]             cond_value_i,
  output sts_t                   sts_o,
  output logic                   grammar_ok_o,
  output logic                   push_overflow_o,
  output logic                   popped_special_o,
  output logic                   top_condition_o,
  output logic                   skip_after_endif_o,
  output logic [DEPTH_OUT_W-1:0] stack_depth_o
);

  entry_t             mem_q [STACK_DEPTH];
  entry_t             top_q;
  logic [CNT_W-1:0]   fill_q;
  logic               gram_q;
  logic               ovf_q;
  logic               pspec_q;
  logic               full;
  logic               gram_d;
  logic [CNT_W-1:0]   rd_cnt;
  entry_t             new_entry;

  assign full          = (fill_q == CNT_W'(STACK_DEPTH));
  assign rd_cnt        = fill_q - CNT_W'(2);
  assign new_entry.dir  = dir_type_i;
  assign new_entry.cond = (cond_value_i != COND_FALSE);
  assign new_entry.spec = (cond_value_i == COND_SPECIAL);

  assign sts_o.empty    = (fill_q == '0);
  assign sts_o.last     = (fill_q == CNT_W'(1));
  assign sts_o.top_open = (top_q.dir == DIR_IF) || (top_q.dir == DIR_IFDEF) ||
                          (top_q.dir == DIR_IFNDEF);

  always_comb begin
    gram_d = 1'b1;
    if (dir_type_i == DIR_ELIF) begin
      if (sts_o.empty || top_q.dir == DIR_ELSE) begin
        gram_d = 1'b0;
      end
    end else if (dir_type_i == DIR_ELSE || dir_type_i == DIR_ENDIF) begin
      if (sts_o.empty) begin
        gram_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      mem_q[fill_q[ADDR_W-1:0]] <= new_entry;
      top_q                     <= new_entry;
    end else if (cmd_i.pop_step && fill_q > CNT_W'(1)) begin
      top_q <= mem_q[rd_cnt[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      gram_q  <= 1'b0;
      ovf_q   <= 1'b0;
      pspec_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        gram_q  <= gram_d;
        ovf_q   <= cmd_i.push && full;
        pspec_q <= 1'b0;
      end
      if (cmd_i.push && !full) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (cmd_i.pop_step) begin
        fill_q <= fill_q - CNT_W'(1);
        if (sts_o.top_open) begin
          pspec_q <= (top_q.dir == DIR_IFDEF) && top_q.spec;
        end
      end
    end
  end

  assign grammar_ok_o       = gram_q;
  assign push_overflow_o    = ovf_q;
  assign popped_special_o   = pspec_q;
  assign top_condition_o    = sts_o.empty ? 1'b1 : top_q.cond;
  assign skip_after_endif_o = !sts_o.empty && !top_q.cond;
  assign stack_depth_o      = DEPTH_OUT_W'(fill_q);

endmodule

FILE: hw/rtl/conditional_directive_stack_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditional directive stack unit
// Tracks nesting of conditional directives on a bounded stack of entries.
// ----------------------------------------------------------------------------
// Push and inspect requests go from the idle state to the done state, which
// raises the result strobe. A pop request on a non-empty stack first walks in
// the pop state, removing and reading one entry of the stack memory per cycle.
// A new request is taken in the cycle after the result strobe.
// Reset empties the stack; the result strobe cannot be stalled.
module conditional_directive_stack_unit
  import cdsu_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             action_i,
  input  logic [2:0]             dir_type_i,
  input  logic [1:0]             cond_value_i,
  output logic                   result_valid_o,
  output logic                   grammar_ok_o,
  output logic                   push_overflow_o,
  output logic                   popped_special_o,
  output logic                   top_condition_o,
  output logic                   skip_after_endif_o,
  output logic [DEPTH_OUT_W-1:0] stack_depth_o
);

  cmd_t cmd;
  sts_t sts;

  cdsu_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .action_i       (action_i),
    .sts_i          (sts),
    .cmd_o          (cmd),
    .busy           (busy),
    .result_valid_o (result_valid_o)
  );

  cdsu_datapath u_datapath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .dir_type_i         (dir_type_i),
    .cond_value_i       (cond_value_i),
    .sts_o              (sts),
    .grammar_ok_o       (grammar_ok_o),
    .push_overflow_o    (push_overflow_o),
    .popped_special_o   (popped_special_o),
    .top_condition_o    (top_condition_o),
    .skip_after_endif_o (skip_after_endif_o),
    .stack_depth_o      (stack_depth_o)
  );

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Conditional directive stack unit testbench
// Drives push, pop and inspect requests through the start/busy handshake.
// A model of the directive stack inside the bench predicts each result, and
// every result strobe is checked field by field in request order.
// ----------------------------------------------------------------------------
module tb_top;
  import cdsu_pkg::*;

  localparam logic [1:0] ACT_UNUSED    = 2'd3;
  localparam logic [2:0] DIR_UNDEF6    = 3'd6;
  localparam logic [2:0] DIR_UNDEF7    = 3'd7;
  localparam logic [1:0] COND_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS = 1800;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [1:0] act;
    logic [2:0] dir;
    logic [1:0] cond;
  } directive_req_t;

  typedef struct packed {
    logic                   grammar_ok;
    logic                   push_overflow;
    logic                   popped_special;
    logic                   top_condition;
    logic                   skip_after_endif;
    logic [DEPTH_OUT_W-1:0] stack_depth;
  } directive_res_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [1:0]             action_i = ACT_INSPECT;
  logic [2:0]             dir_type_i = DIR_IF;
  logic [1:0]             cond_value_i = COND_FALSE;
  logic                   result_valid_o;
  logic                   grammar_ok_o;
  logic                   push_overflow_o;
  logic                   popped_special_o;
  logic                   top_condition_o;
  logic                   skip_after_endif_o;
  logic [DEPTH_OUT_W-1:0] stack_depth_o;

  directive_req_t directive_q[$];
  directive_res_t result_q[$];
  entry_t         dstack[STACK_DEPTH];
  int             dstack_fill = 0;
  int             total_items = 0;
  int             n_accepted = 0;
  int             n_random = 0;
  int             idle_cycles = 0;
  int             err_count = 0;
  bit             req_taken = 1'b0;

  conditional_directive_stack_unit u_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .start              (start),
    .busy               (busy),
    .action_i           (action_i),
    .dir_type_i         (dir_type_i),
    .cond_value_i       (cond_value_i),
    .result_valid_o     (result_valid_o),
    .grammar_ok_o       (grammar_ok_o),
    .push_overflow_o    (push_overflow_o),
    .popped_special_o   (popped_special_o),
    .top_condition_o    (top_condition_o),
    .skip_after_endif_o (skip_after_endif_o),
    .stack_depth_o      (stack_depth_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    $display("tb_top: mismatch: %s", msg);
    err_count++;
  endtask

  function automatic void predict_directive(input logic [1:0] act, input logic [2:0] dir,
                                            input logic [1:0] cond);
    directive_res_t r;
    logic [2:0]     t;
    logic           s;
    bit             done;
    r = '0;
    r.grammar_ok = 1'b1;
    if (dir == DIR_ELIF) begin
      if (dstack_fill == 0 || dstack[dstack_fill-1].dir == DIR_ELSE) r.grammar_ok = 1'b0;
    end else if (dir == DIR_ELSE || dir == DIR_ENDIF) begin
      if (dstack_fill == 0) r.grammar_ok = 1'b0;
    end
    if (act == ACT_PUSH) begin
      if (dstack_fill >= STACK_DEPTH) begin
        r.push_overflow = 1'b1;
      end else begin
        dstack[dstack_fill] = '{dir: dir, cond: (cond != COND_FALSE),
                                spec: (cond == COND_SPECIAL)};
        dstack_fill++;
      end
    end else if (act == ACT_POP) begin
      done = 1'b0;
      while (dstack_fill > 0 && !done) begin
        t = dstack[dstack_fill-1].dir;
        s = dstack[dstack_fill-1].spec;
        dstack_fill--;
        if (t == DIR_IF || t == DIR_IFDEF || t == DIR_IFNDEF) begin
          r.popped_special = (t == DIR_IFDEF) && s;
          done = 1'b1;
        end
      end
    end
    if (dstack_fill == 0) begin
      r.top_condition = 1'b1;
      r.skip_after_endif = 1'b0;
    end else begin
      r.top_condition = dstack[dstack_fill-1].cond;
      r.skip_after_endif = !r.top_condition;
    end
    r.stack_depth = DEPTH_OUT_W'(dstack_fill);
    result_q.push_back(r);
  endfunction

  function automatic void add_directive(input logic [1:0] act, input logic [2:0] dir,
                                        input logic [1:0] cond);
    directive_q.push_back('{act: act, dir: dir, cond: cond});
    n_random++;
  endfunction

  function automatic logic [1:0] rand_cond();
    return 2'($urandom_range(2));
  endfunction

  // A conditional block with optional elif, else, inspects and nested blocks.
  task automatic gen_block(input int lvl);
    int n;
    add_directive(ACT_PUSH, 3'($urandom_range(2)), rand_cond());
    n = $urandom_range(3);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(3))
        0: add_directive(ACT_INSPECT, 3'($urandom_range(5)), rand_cond());
        1: add_directive(ACT_PUSH, DIR_ELIF, rand_cond());
        default: begin
          if (lvl < 5) gen_block(lvl + 1);
          else add_directive(ACT_INSPECT, DIR_ENDIF, rand_cond());
        end
      endcase
    end
    if ($urandom_range(1)) add_directive(ACT_PUSH, DIR_ELSE, rand_cond());
    if ($urandom_range(3) == 0) add_directive(ACT_INSPECT, DIR_ELIF, rand_cond());
    add_directive(ACT_POP, DIR_ENDIF, rand_cond());
  endtask

  function automatic int idle_pct();
    if (n_accepted < total_items / 3) return 34;
    if (n_accepted < 2 * total_items / 3) return 58;
    return 0;
  endfunction

  always @(negedge clk_i) begin
    directive_req_t nxt;
    if (rst_ni && (!start || req_taken)) begin
      req_taken = 1'b0;
      if (directive_q.size() != 0 && $urandom_range(99) >= idle_pct()) begin
        nxt = directive_q.pop_front();
        action_i     <= nxt.act;
        dir_type_i   <= nxt.dir;
        cond_value_i <= nxt.cond;
        start        <= 1'b1;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    directive_res_t want;
    bit             progress;
    if (rst_ni) begin
      progress = 1'b0;
      if (start && !busy) begin
        predict_directive(action_i, dir_type_i, cond_value_i);
        req_taken = 1'b1;
        n_accepted++;
        progress = 1'b1;
      end
      if (result_valid_o === 1'b1) begin
        progress = 1'b1;
        if (result_q.size() == 0) begin
          report_mismatch("result strobe with no request outstanding");
        end else begin
          want = result_q.pop_front();
          if (grammar_ok_o !== want.grammar_ok)
            report_mismatch($sformatf("grammar_ok got %b want %b", grammar_ok_o,
                                      want.grammar_ok));
          if (push_overflow_o !== want.push_overflow)
            report_mismatch($sformatf("push_overflow got %b want %b", push_overflow_o,
                                      want.push_overflow));
          if (popped_special_o !== want.popped_special)
            report_mismatch($sformatf("popped_special got %b want %b", popped_special_o,
                                      want.popped_special));
          if (top_condition_o !== want.top_condition)
            report_mismatch($sformatf("top_condition got %b want %b", top_condition_o,
                                      want.top_condition));
          if (skip_after_endif_o !== want.skip_after_endif)
            report_mismatch($sformatf("skip_after_endif got %b want %b", skip_after_endif_o,
                                      want.skip_after_endif));
          if (stack_depth_o !== want.stack_depth)
            report_mismatch($sformatf("stack_depth got %0d want %0d", stack_depth_o,
                                      want.stack_depth));
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  always @(negedge clk_i) begin
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    // Empty stack: grammar of every closing type, unused codes, pop with nothing held.
    add_directive(ACT_INSPECT, DIR_IF, COND_FALSE);
    add_directive(ACT_INSPECT, DIR_ELIF, COND_TRUE);
    add_directive(ACT_INSPECT, DIR_ELSE, COND_SPECIAL);
    add_directive(ACT_INSPECT, DIR_ENDIF, COND_FALSE);
    add_directive(ACT_UNUSED, DIR_UNDEF7, COND_RESERVED);
    add_directive(ACT_POP, DIR_ENDIF, COND_FALSE);
    // Pop that walks over non-opening entries down to a special ifdef.
    add_directive(ACT_PUSH, DIR_IF, COND_TRUE);
    add_directive(ACT_PUSH, DIR_IFDEF, COND_SPECIAL);
    add_directive(ACT_PUSH, DIR_ELSE, COND_FALSE);
    add_directive(ACT_INSPECT, DIR_ELIF, COND_FALSE);
    add_directive(ACT_PUSH, DIR_ELIF, COND_RESERVED);
    add_directive(ACT_PUSH, DIR_UNDEF6, COND_FALSE);
    add_directive(ACT_PUSH, DIR_UNDEF7, COND_TRUE);
    add_directive(ACT_POP, DIR_ENDIF, COND_FALSE);
    add_directive(ACT_POP, DIR_ENDIF, COND_FALSE);
    // Pop with no opening entry removes everything.
    add_directive(ACT_PUSH, DIR_ENDIF, COND_FALSE);
    add_directive(ACT_PUSH, DIR_ELSE, COND_TRUE);
    add_directive(ACT_POP, DIR_ENDIF, COND_TRUE);
    // The special flag only counts on an ifdef.
    add_directive(ACT_PUSH, DIR_IFNDEF, COND_SPECIAL);
    add_directive(ACT_POP, DIR_ENDIF, COND_FALSE);
    add_directive(ACT_PUSH, DIR_IFDEF, COND_TRUE);
    add_directive(ACT_INSPECT, DIR_ENDIF, COND_FALSE);
    add_directive(ACT_POP, DIR_ENDIF, COND_FALSE);

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      case ($urandom_range(14))
        10: begin
          // Fill past capacity, then drain past empty.
          for (int i = 0; i < STACK_DEPTH + 2; i++)
            add_directive(ACT_PUSH, 3'($urandom_range(7)), 2'($urandom_range(3)));
          add_directive(ACT_INSPECT, 3'($urandom_range(7)), 2'($urandom_range(3)));
          for (int i = 0; i < STACK_DEPTH + 4; i++)
            add_directive(ACT_POP, 3'($urandom_range(7)), 2'($urandom_range(3)));
        end
        11, 12: begin
          repeat ($urandom_range(1, 6))
            add_directive(2'($urandom_range(3)), 3'($urandom_range(7)),
                          2'($urandom_range(3)));
        end
        13, 14: begin
          repeat ($urandom_range(1, 4))
            add_directive(ACT_PUSH, 3'($urandom_range(3, 7)), 2'($urandom_range(3)));
          add_directive(ACT_POP, 3'($urandom_range(7)), 2'($urandom_range(3)));
        end
        default: gen_block(0);
      endcase
    end
    total_items = directive_q.size();

    repeat (10) @(posedge clk_i);
    @(negedge clk_i) rst_ni = 1'b1;

    while (directive_q.size() != 0 || start) @(posedge clk_i);
    while (result_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (err_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

FILE: sim.f
hw/rtl/cdsu_pkg.sv
hw/rtl/cdsu_ctrl.sv
hw/rtl/cdsu_datapath.sv
hw/rtl/conditional_directive_stack_unit.sv
verif/tb_top.sv
